[src/plu_pkg.sv]
// Package: shared types, register indexes and Q4.28 fixed-point helpers.
package plu_pkg;

    localparam int UNDISTORT_ITERATIONS = 8;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_FOCAL_X   = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X          = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_FOCAL_Y   = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y          = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIAL_FIRST      = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIAL_SECOND     = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TANGENTIAL_FIRST  = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TANGENTIAL_SECOND = 4'd7;

    typedef logic signed [31:0] q_t;

    // Point in flight: normalized point and current estimate.
    typedef struct packed {
        q_t xd;
        q_t yd;
        q_t xu;
        q_t yu;
    } pt_t;

    typedef struct packed {
        q_t k1;
        q_t k2;
        q_t p1;
        q_t p2;
    } coef_t;

    function automatic q_t sat32(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q4.28 product, round half up, saturated.
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd134217728;
        return sat32(p >>> 28);
    endfunction

endpackage

[src/pinhole_lift_undistort.sv]
// Top level: configuration registers, normalization and unrolled undistortion pipeline.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_pixel_x, s_pixel_y
//  m_       out        m_valid / m_ready    m_ray_x, m_ray_y
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while m_ready is high; the normalization stage is
// followed by UNDISTORT_ITERATIONS unrolled iterations of multiply/round/saturate.
// Every stage has its own valid bit and holds while the next is full, so bubbles
// collapse under back-pressure. cfg_ready is always high. Reset clears the valid
// bits and the configuration registers; data registers are left as they are.
module pinhole_lift_undistort (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pixel_x,
    input  logic [15:0] s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_ray_x,
    output logic signed [31:0] m_ray_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [plu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int N = plu_pkg::UNDISTORT_ITERATIONS;

    logic [31:0] inv_x_reg, off_x_reg, inv_y_reg, off_y_reg;
    logic [31:0] k1_reg, k2_reg, p1_reg, p2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_x_reg <= '0;
            off_x_reg <= '0;
            inv_y_reg <= '0;
            off_y_reg <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                plu_pkg::REG_INVERSE_FOCAL_X:   inv_x_reg <= cfg_data;
                plu_pkg::REG_OFFSET_X:          off_x_reg <= cfg_data;
                plu_pkg::REG_INVERSE_FOCAL_Y:   inv_y_reg <= cfg_data;
                plu_pkg::REG_OFFSET_Y:          off_y_reg <= cfg_data;
                plu_pkg::REG_RADIAL_FIRST:      k1_reg    <= cfg_data;
                plu_pkg::REG_RADIAL_SECOND:     k2_reg    <= cfg_data;
                plu_pkg::REG_TANGENTIAL_FIRST:  p1_reg    <= cfg_data;
                plu_pkg::REG_TANGENTIAL_SECOND: p2_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    plu_pkg::coef_t coef;
    assign coef.k1 = k1_reg;
    assign coef.k2 = k2_reg;
    assign coef.p1 = p1_reg;
    assign coef.p2 = p2_reg;

    logic         valid_c [N+1];
    logic         ready_c [N+1];
    plu_pkg::pt_t data_c  [N+1];

    plu_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pix_x     (s_pixel_x),
        .pix_y     (s_pixel_y),
        .inv_x     (inv_x_reg),
        .inv_y     (inv_y_reg),
        .off_x     (off_x_reg),
        .off_y     (off_y_reg),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_data  (data_c[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_iter
        plu_iter u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef      (coef),
            .in_valid  (valid_c[g]),
            .in_ready  (ready_c[g]),
            .in_data   (data_c[g]),
            .out_valid (valid_c[g+1]),
            .out_ready (ready_c[g+1]),
            .out_data  (data_c[g+1])
        );
    end

    assign ready_c[N] = m_ready;
    assign m_valid    = valid_c[N];
    assign m_ray_x    = data_c[N].xu;
    assign m_ray_y    = data_c[N].yu;

endmodule

[src/plu_norm.sv]
// Normalization stage: pixel times inverse focal plus offset, one register stage.
module plu_norm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        pix_x,
    input  logic [15:0]        pix_y,
    input  logic [31:0]        inv_x,
    input  logic [31:0]        inv_y,
    input  plu_pkg::q_t        off_x,
    input  plu_pkg::q_t        off_y,
    output logic               out_valid,
    input  logic               out_ready,
    output plu_pkg::pt_t       out_data
);

    logic         valid_reg;
    plu_pkg::pt_t data_reg;
    plu_pkg::pt_t data_next;
    logic         en;

    logic [47:0]  prod_x;
    logic [47:0]  prod_y;
    logic [39:0]  q_x;
    logic [39:0]  q_y;
    plu_pkg::q_t  d_x;
    plu_pkg::q_t  d_y;

    assign en = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        prod_x = 48'(pix_x) * 48'(inv_x);
        prod_y = 48'(pix_y) * 48'(inv_y);
        q_x = 40'((prod_x + 48'd128) >> 8);
        q_y = 40'((prod_y + 48'd128) >> 8);
        d_x = plu_pkg::sat32($signed({24'd0, q_x}) + 64'(off_x));
        d_y = plu_pkg::sat32($signed({24'd0, q_y}) + 64'(off_y));
        data_next.xd = d_x;
        data_next.yd = d_y;
        data_next.xu = d_x;
        data_next.yu = d_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/plu_iter.sv]
// One undistortion iteration, u = sat(d - D(u)), as a seven-stage pipeline.
module plu_iter (
    input  logic               aclk,
    input  logic               aresetn,
    input  plu_pkg::coef_t     coef,
    input  logic               in_valid,
    output logic               in_ready,
    input  plu_pkg::pt_t       in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output plu_pkg::pt_t       out_data
);

    localparam int NSTAGE = 7;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;

    // each stage holds unless the next one can take its request
    always_comb begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    plu_pkg::pt_t pt1_reg, pt2_reg, pt3_reg, pt4_reg, pt5_reg, pt6_reg, pt7_reg;
    plu_pkg::q_t  x2_1_reg, y2_1_reg, xy_1_reg;
    plu_pkg::q_t  x2_2_reg, y2_2_reg, xy_2_reg, r2_2_reg;
    plu_pkg::q_t  r4_3_reg, kr_3_reg, tx_3_reg, ty_3_reg, pa_3_reg, pb_3_reg;
    plu_pkg::q_t  kr_4_reg, kr4_4_reg, mtx_4_reg, mty_4_reg, pa_4_reg, pb_4_reg;
    plu_pkg::q_t  rad_5_reg, mtx_5_reg, mty_5_reg, pa_5_reg, pb_5_reg;
    plu_pkg::q_t  mxr_6_reg, myr_6_reg, mtx_6_reg, mty_6_reg, pa_6_reg, pb_6_reg;
    plu_pkg::q_t  dx, dy;

    always_comb begin
        dx = plu_pkg::sat32(64'(mxr_6_reg) + (64'(pa_6_reg) <<< 1) + 64'(mtx_6_reg));
        dy = plu_pkg::sat32(64'(myr_6_reg) + (64'(pb_6_reg) <<< 1) + 64'(mty_6_reg));
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pt1_reg  <= in_data;
            x2_1_reg <= plu_pkg::qmul(in_data.xu, in_data.xu);
            y2_1_reg <= plu_pkg::qmul(in_data.yu, in_data.yu);
            xy_1_reg <= plu_pkg::qmul(in_data.xu, in_data.yu);
        end
        if (en[1]) begin
            pt2_reg  <= pt1_reg;
            x2_2_reg <= x2_1_reg;
            y2_2_reg <= y2_1_reg;
            xy_2_reg <= xy_1_reg;
            r2_2_reg <= plu_pkg::sat32(64'(x2_1_reg) + 64'(y2_1_reg));
        end
        if (en[2]) begin
            pt3_reg  <= pt2_reg;
            r4_3_reg <= plu_pkg::qmul(r2_2_reg, r2_2_reg);
            kr_3_reg <= plu_pkg::qmul(coef.k1, r2_2_reg);
            tx_3_reg <= plu_pkg::sat32(64'(r2_2_reg) + (64'(x2_2_reg) <<< 1));
            ty_3_reg <= plu_pkg::sat32(64'(r2_2_reg) + (64'(y2_2_reg) <<< 1));
            pa_3_reg <= plu_pkg::qmul(coef.p1, xy_2_reg);
            pb_3_reg <= plu_pkg::qmul(coef.p2, xy_2_reg);
        end
        if (en[3]) begin
            pt4_reg   <= pt3_reg;
            kr_4_reg  <= kr_3_reg;
            kr4_4_reg <= plu_pkg::qmul(coef.k2, r4_3_reg);
            mtx_4_reg <= plu_pkg::qmul(coef.p2, tx_3_reg);
            mty_4_reg <= plu_pkg::qmul(coef.p1, ty_3_reg);
            pa_4_reg  <= pa_3_reg;
            pb_4_reg  <= pb_3_reg;
        end
        if (en[4]) begin
            pt5_reg   <= pt4_reg;
            rad_5_reg <= plu_pkg::sat32(64'(kr_4_reg) + 64'(kr4_4_reg));
            mtx_5_reg <= mtx_4_reg;
            mty_5_reg <= mty_4_reg;
            pa_5_reg  <= pa_4_reg;
            pb_5_reg  <= pb_4_reg;
        end
        if (en[5]) begin
            pt6_reg   <= pt5_reg;
            mxr_6_reg <= plu_pkg::qmul(pt5_reg.xu, rad_5_reg);
            myr_6_reg <= plu_pkg::qmul(pt5_reg.yu, rad_5_reg);
            mtx_6_reg <= mtx_5_reg;
            mty_6_reg <= mty_5_reg;
            pa_6_reg  <= pa_5_reg;
            pb_6_reg  <= pb_5_reg;
        end
        if (en[6]) begin
            pt7_reg.xd <= pt6_reg.xd;
            pt7_reg.yd <= pt6_reg.yd;
            pt7_reg.xu <= plu_pkg::sat32(64'(pt6_reg.xd) - 64'(dx));
            pt7_reg.yu <= plu_pkg::sat32(64'(pt6_reg.yd) - 64'(dy));
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign out_data  = pt7_reg;

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (v_reg == '1))
        else $error("iteration refused a request with a free stage");
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted request not in first stage");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled iteration output changed");
`endif

endmodule

[dv/tb_pinhole_lift_undistort.sv]
// Testbench for pinhole_lift_undistort: directed table plus random points, checked against a predictor.
module tb_pinhole_lift_undistort;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [plu_pkg::CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 4'd9;
    localparam int SETTLE_CYCLES = 1 + 7 * plu_pkg::UNDISTORT_ITERATIONS + 8;
    localparam int RANDOM_PHASES = 6;
    localparam int POINTS_PER_PHASE = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_pixel_x = '0;
    logic [15:0] s_pixel_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_ray_x;
    logic signed [31:0] m_ray_y;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [plu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pinhole_lift_undistort u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_ray_x   (m_ray_x),
        .m_ray_y   (m_ray_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } ray_t;

    typedef struct {
        bit          is_cfg;
        logic [plu_pkg::CFG_INDEX_WIDTH-1:0] idx;
        logic [31:0] data;
        logic [15:0] px;
        logic [15:0] py;
        bit          known;
        ray_t        ray;
    } row_t;

    logic [31:0] lens_regs [8];
    ray_t        ray_expect_q[$];
    row_t        directed_rows[$];
    int          errors = 0;
    bit          calm = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic longint clip_q(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< 27);
        return clip_q(p >>> 28);
    endfunction

    function automatic longint to_plane(input logic [15:0] pix, input logic [31:0] inv,
                                        input logic [31:0] off);
        logic [63:0] prod;
        prod = {48'd0, pix} * {32'd0, inv};
        return clip_q(longint'((prod + 64'd128) >> 8) + longint'($signed(off)));
    endfunction

    function automatic ray_t lift_point(input logic [15:0] px, input logic [15:0] py);
        longint xd, yd, xu, yu, k1, k2, p1, p2;
        longint x2, y2, xy, r2, r4, rad, dx, dy;
        ray_t r;
        k1 = $signed(lens_regs[plu_pkg::REG_RADIAL_FIRST]);
        k2 = $signed(lens_regs[plu_pkg::REG_RADIAL_SECOND]);
        p1 = $signed(lens_regs[plu_pkg::REG_TANGENTIAL_FIRST]);
        p2 = $signed(lens_regs[plu_pkg::REG_TANGENTIAL_SECOND]);
        xd = to_plane(px, lens_regs[plu_pkg::REG_INVERSE_FOCAL_X],
                      lens_regs[plu_pkg::REG_OFFSET_X]);
        yd = to_plane(py, lens_regs[plu_pkg::REG_INVERSE_FOCAL_Y],
                      lens_regs[plu_pkg::REG_OFFSET_Y]);
        xu = xd;
        yu = yd;
        for (int i = 0; i < plu_pkg::UNDISTORT_ITERATIONS; i++) begin
            x2 = fix_mul(xu, xu);
            y2 = fix_mul(yu, yu);
            xy = fix_mul(xu, yu);
            r2 = clip_q(x2 + y2);
            r4 = fix_mul(r2, r2);
            rad = clip_q(fix_mul(k1, r2) + fix_mul(k2, r4));
            dx = clip_q(fix_mul(xu, rad) + 2 * fix_mul(p1, xy)
                        + fix_mul(p2, clip_q(r2 + 2 * x2)));
            dy = clip_q(fix_mul(yu, rad) + 2 * fix_mul(p2, xy)
                        + fix_mul(p1, clip_q(r2 + 2 * y2)));
            xu = clip_q(xd - dx);
            yu = clip_q(yd - dy);
        end
        r.x = xu[31:0];
        r.y = yu[31:0];
        return r;
    endfunction

    // ---------------- result side ----------------
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) < 7) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
        end
    end

    always @(posedge aclk) begin
        ray_t want;
        if (aresetn && m_valid && m_ready) begin
            if (ray_expect_q.size() == 0) begin
                $display("%0t: unexpected ray x=%h y=%h", $realtime, m_ray_x, m_ray_y);
                errors++;
            end else begin
                want = ray_expect_q.pop_front();
                if (m_ray_x !== want.x) begin
                    $display("%0t: ray_x expected %h actual %h", $realtime, want.x, m_ray_x);
                    errors++;
                end
                if (m_ray_y !== want.y) begin
                    $display("%0t: ray_y expected %h actual %h", $realtime, want.y, m_ray_y);
                    errors++;
                end
            end
        end
    end

    // ---------------- request side ----------------
    task automatic drain();
        while (ray_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high; caller lowers it after the last write
    task automatic write_reg(input logic [plu_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < 8) lens_regs[idx] = val;
    endtask

    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input bit known, input ray_t ray);
        ray_t pred;
        int gap;
        s_valid   <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = lift_point(px, py);
        if (known && (pred.x !== ray.x || pred.y !== ray.y)) begin
            $display("%0t: table row px=%h py=%h expected %h/%h, predictor %h/%h",
                     $realtime, px, py, ray.x, ray.y, pred.x, pred.y);
            errors++;
        end
        ray_expect_q.push_back(known ? ray : pred);
        gap = 0;
        if (!calm) begin
            case ($urandom_range(0, 19))
                0:       gap = $urandom_range(10, 40);
                1, 2, 3,
                4, 5, 6: gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic add_cfg(input logic [plu_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [31:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = val;
        directed_rows.push_back(r);
    endtask

    task automatic add_pt(input logic [15:0] px, input logic [15:0] py, input bit known,
                          input logic [31:0] ex, input logic [31:0] ey);
        row_t r;
        r = '{default: '0};
        r.px = px;
        r.py = py;
        r.known = known;
        r.ray.x = ex;
        r.ray.y = ey;
        directed_rows.push_back(r);
    endtask

    function automatic logic [31:0] pick_word(input logic [31:0] typical);
        case ($urandom_range(0, 7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return 32'hffffffff;
            4:       return $urandom();
            default: return typical + $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    initial begin
        ray_t none;
        row_t r;
        bit cfg_open;
        logic [31:0] typical [8];

        none = '{x: '0, y: '0};
        foreach (lens_regs[i]) lens_regs[i] = '0;

        // all registers zero after reset: every ray is the origin
        add_pt(16'h0000, 16'h0000, 1'b1, 32'h0, 32'h0);
        add_pt(16'hffff, 16'hffff, 1'b1, 32'h0, 32'h0);
        add_pt(16'h8000, 16'h1234, 1'b1, 32'h0, 32'h0);
        // widest focal scale, no offset, no distortion
        add_cfg(plu_pkg::REG_INVERSE_FOCAL_X, 32'hffffffff);
        add_cfg(plu_pkg::REG_INVERSE_FOCAL_Y, 32'hffffffff);
        add_pt(16'hffff, 16'hffff, 1'b1, 32'h7fffffff, 32'h7fffffff);
        add_pt(16'h0000, 16'h0000, 1'b1, 32'h0, 32'h0);
        add_pt(16'h0001, 16'h5555, 1'b0, 32'h0, 32'h0);
        add_cfg(plu_pkg::REG_OFFSET_X, 32'h80000000);
        add_cfg(plu_pkg::REG_OFFSET_Y, 32'h80000000);
        add_pt(16'h0000, 16'h0000, 1'b1, 32'h80000000, 32'h80000000);
        add_pt(16'hffff, 16'hffff, 1'b1, 32'h7fffffff, 32'h7fffffff);
        add_pt(16'haaaa, 16'h0100, 1'b0, 32'h0, 32'h0);
        // write to an unmapped index must not disturb anything
        add_cfg(REG_UNMAPPED, 32'hffffffff);
        add_pt(16'h0000, 16'h0000, 1'b1, 32'h80000000, 32'h80000000);
        // extreme coefficients, saturation everywhere
        add_cfg(plu_pkg::REG_RADIAL_FIRST, 32'h7fffffff);
        add_cfg(plu_pkg::REG_RADIAL_SECOND, 32'h80000000);
        add_cfg(plu_pkg::REG_TANGENTIAL_FIRST, 32'h7fffffff);
        add_cfg(plu_pkg::REG_TANGENTIAL_SECOND, 32'h80000000);
        add_pt(16'h0000, 16'hffff, 1'b0, 32'h0, 32'h0);
        add_pt(16'hffff, 16'h0000, 1'b0, 32'h0, 32'h0);
        add_pt(16'h7fff, 16'h8000, 1'b0, 32'h0, 32'h0);
        // plausible 640x480 camera, f = 500 px, mild barrel distortion
        add_cfg(plu_pkg::REG_INVERSE_FOCAL_X, 32'd8589935);
        add_cfg(plu_pkg::REG_OFFSET_X, -32'sd171798692);
        add_cfg(plu_pkg::REG_INVERSE_FOCAL_Y, 32'd8589935);
        add_cfg(plu_pkg::REG_OFFSET_Y, -32'sd128849019);
        add_cfg(plu_pkg::REG_RADIAL_FIRST, -32'sd80530637);
        add_cfg(plu_pkg::REG_RADIAL_SECOND, 32'sd26843546);
        add_cfg(plu_pkg::REG_TANGENTIAL_FIRST, 32'sd268435);
        add_cfg(plu_pkg::REG_TANGENTIAL_SECOND, -32'sd134218);
        add_pt(16'd5120, 16'd3840, 1'b0, 32'h0, 32'h0);
        add_pt(16'd0, 16'd0, 1'b0, 32'h0, 32'h0);
        add_pt(16'd10239, 16'd7679, 1'b0, 32'h0, 32'h0);
        add_pt(16'd1000, 16'd7000, 1'b0, 32'h0, 32'h0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_open = 1'b0;
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.is_cfg) begin
                if (!cfg_open) begin
                    s_valid <= 1'b0;
                    drain();
                end
                write_reg(r.idx, r.data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_point(r.px, r.py, r.known, r.ray);
            end
        end

        for (int i = 0; i < 8; i++) typical[i] = lens_regs[i];
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            s_valid <= 1'b0;
            drain();
            calm = (ph == 1);
            for (int k = 0; k < 8; k++) begin
                write_reg(k[plu_pkg::CFG_INDEX_WIDTH-1:0],
                          (ph == 0) ? typical[k] : pick_word(typical[k]));
            end
            if ($urandom_range(0, 1)) write_reg(REG_UNMAPPED, $urandom());
            // one phase with no distortion at all
            if (ph == 3) begin
                write_reg(plu_pkg::REG_RADIAL_FIRST, '0);
                write_reg(plu_pkg::REG_RADIAL_SECOND, '0);
                write_reg(plu_pkg::REG_TANGENTIAL_FIRST, '0);
                write_reg(plu_pkg::REG_TANGENTIAL_SECOND, '0);
            end
            cfg_valid <= 1'b0;
            for (int n = 0; n < POINTS_PER_PHASE; n++) begin
                // mostly in-image points, some anywhere in the field range
                if ($urandom_range(0, 3) == 0) begin
                    send_point(16'($urandom()), 16'($urandom()), 1'b0, none);
                end else begin
                    send_point(16'($urandom_range(0, 10239)), 16'($urandom_range(0, 7679)),
                               1'b0, none);
                end
            end
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (ray_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/plu_pkg.sv
src/plu_norm.sv
src/plu_iter.sv
src/pinhole_lift_undistort.sv
dv/tb_pinhole_lift_undistort.sv
